FILE: src/rhs_pkg.sv
// shared types and constants for the recent hash set
`default_nettype none
package rhs_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned EntryCountW = 7;
  localparam int unsigned DefDepth    = 64;

  typedef enum logic {
    CmdQuery = 1'b0,
    CmdAdd   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StReduce,
    StOut
  } state_e;

endpackage
`default_nettype wire

FILE: src/rhs_cell.sv
// one storage cell of the key chain: holds a key, shifts on add, compares on every item
`default_nettype none
module rhs_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      shift_i,
  input  wire logic                      cmp_i,
  input  wire logic [rhs_pkg::KeyW-1:0]  key_i,
  input  wire logic                      valid_i,
  input  wire logic [rhs_pkg::KeyW-1:0]  query_i,
  output logic      [rhs_pkg::KeyW-1:0]  key_o,
  output logic                           valid_o,
  output logic                           hit_o
);

  logic [rhs_pkg::KeyW-1:0] key_q;
  logic                     valid_q;
  logic                     hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      if (shift_i) begin
        valid_q <= valid_i;
      end
      if (cmp_i) begin
        hit_q <= valid_q && (key_q == query_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q <= key_i;
    end
  end

  assign key_o   = key_q;
  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule
`default_nettype wire

FILE: src/recent_hash_set_fifo_evict.sv
// recent hash set top level: chain of key cells with count and result register
// an accepted item moves through StReduce into StOut; one item in flight at a time
// a new item is taken only in StIdle, after the result has been accepted, so an output stall holds the input
// add shifts the key into the head cell; the tail cell drops the oldest key
// query compares all cells in the accept cycle, the hit bits are or-reduced next
// reset empties all cells and clears the count, no clearing pass
`default_nettype none
module recent_hash_set_fifo_evict #(
  parameter int unsigned DEPTH = rhs_pkg::DefDepth
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            cmd_i,
  input  wire logic [rhs_pkg::KeyW-1:0]        key_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 found_o,
  output logic      [rhs_pkg::EntryCountW-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned OutW = rhs_pkg::EntryCountW;

  rhs_pkg::state_e state_q, state_d;

  logic                   accept;
  logic                   shift;
  logic                   cmd_q;
  logic [CntW-1:0]        count_q;
  logic                   found_q;
  logic [CntW-1:0]        count_out_q;

  logic [rhs_pkg::KeyW-1:0] chain_key   [DEPTH+1];
  logic [DEPTH:0]           chain_valid;
  logic [DEPTH-1:0]         hits;

  assign in_ready_o = (state_q == rhs_pkg::StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = accept && (cmd_i == rhs_pkg::CmdAdd);

  assign chain_key[0]   = key_i;
  assign chain_valid[0] = 1'b1;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    rhs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .cmp_i   (accept),
      .key_i   (chain_key[g]),
      .valid_i (chain_valid[g]),
      .query_i (key_i),
      .key_o   (chain_key[g+1]),
      .valid_o (chain_valid[g+1]),
      .hit_o   (hits[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhs_pkg::StIdle;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (shift && (count_q != CntW'(DEPTH))) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    if (state_q == rhs_pkg::StReduce) begin
      found_q     <= (cmd_q == rhs_pkg::CmdQuery) && (|hits);
      count_out_q <= count_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rhs_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = rhs_pkg::StReduce;
        end
      end
      rhs_pkg::StReduce: begin
        state_d = rhs_pkg::StOut;
      end
      rhs_pkg::StOut: begin
        if (out_ready_i) begin
          state_d = rhs_pkg::StIdle;
        end
      end
      default: begin
        state_d = rhs_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o = (state_q == rhs_pkg::StOut);
  assign found_o     = found_q;

  if (CntW >= OutW) begin : g_cnt_trunc
    assign entry_count_o = count_out_q[OutW-1:0];
  end else begin : g_cnt_ext
    assign entry_count_o = {{(OutW-CntW){1'b0}}, count_out_q};
  end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// testbench for the recent hash set: queued stimulus, handshake driver, result checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth     = rhs_pkg::DefDepth;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold  = 400;
  localparam int unsigned NumRandom = 1580;

  typedef struct {
    rhs_pkg::cmd_e            cmd;
    logic [rhs_pkg::KeyW-1:0] key;
    int unsigned              gap;
    bit                       drain;
  } hash_item_t;

  typedef struct {
    logic                            found;
    logic [rhs_pkg::EntryCountW-1:0] count;
  } set_result_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic                            cmd_i = 1'b0;
  logic [rhs_pkg::KeyW-1:0]        key_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            found_o;
  logic [rhs_pkg::EntryCountW-1:0] entry_count_o;

  hash_item_t               pending_items[$];
  logic [rhs_pkg::KeyW-1:0] held_keys[$];
  set_result_t              expected_results[$];

  hash_item_t  cur_item;
  bit          item_sent;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned n_results;
  int unsigned idle_cycles;
  int unsigned n_failures;
  bit          long_hold_done;

  recent_hash_set_fifo_evict #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // fifo set with oldest-first eviction
  task automatic apply_to_set(input rhs_pkg::cmd_e cmd, input logic [rhs_pkg::KeyW-1:0] key);
    set_result_t res;
    res.found = 1'b0;
    if (cmd == rhs_pkg::CmdAdd) begin
      if (held_keys.size() >= Depth) void'(held_keys.pop_front());
      held_keys.push_back(key);
    end else begin
      foreach (held_keys[i]) if (held_keys[i] == key) res.found = 1'b1;
    end
    res.count = rhs_pkg::EntryCountW'(held_keys.size());
    expected_results.push_back(res);
  endtask

  task automatic note_failure(input string msg);
    if (n_failures < 10) $display("mismatch: %s", msg);
    n_failures++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      item_sent = in_valid_i && in_ready_o;
      if (item_sent) apply_to_set(cur_item.cmd, cur_item.key);
      if (!in_valid_i || item_sent) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_results.size() != 0)) begin
          cur_item = pending_items.pop_front();
          gap_left = cur_item.gap;
          in_valid_i <= 1'b1;
          cmd_i <= cur_item.cmd;
          key_i <= cur_item.key;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result found=%0b count=%0d",
                                 found_o, entry_count_o));
        end else begin
          want = expected_results.pop_front();
          if (found_o !== want.found || entry_count_o !== want.count)
            note_failure($sformatf("result %0d: found exp %0b act %0b, count exp %0d act %0d",
                                   n_results, want.found, found_o, want.count,
                                   entry_count_o));
        end
        n_results++;
      end
      if (n_results >= 900 && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        // quiet stretch with no receiver stalls
        if (!(n_results >= 400 && n_results < 600) && $urandom_range(3) == 0)
          stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without progress", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    hash_item_t               it;
    logic [rhs_pkg::KeyW-1:0] recent_keys[$];
    logic [rhs_pkg::KeyW-1:0] corner_keys[$];
    int unsigned              r;
    int unsigned              add_pct;

    corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                    32'h5555_5555, 32'hAAAA_AAAA};
    it.gap = 0;
    it.drain = 1'b0;
    // empty set queries, then extremes, a duplicate and near misses
    it.cmd = rhs_pkg::CmdQuery; it.key = 32'h0000_0000; pending_items.push_back(it);
    it.cmd = rhs_pkg::CmdQuery; it.key = 32'hFFFF_FFFF; pending_items.push_back(it);
    foreach (corner_keys[i]) begin
      it.cmd = rhs_pkg::CmdAdd; it.key = corner_keys[i]; pending_items.push_back(it);
      it.cmd = rhs_pkg::CmdQuery; pending_items.push_back(it);
      it.key = corner_keys[i] ^ 32'h0000_0100; pending_items.push_back(it);
      recent_keys.push_back(corner_keys[i]);
    end
    it.cmd = rhs_pkg::CmdAdd; it.key = 32'h0000_0000; pending_items.push_back(it);
    it.cmd = rhs_pkg::CmdQuery; pending_items.push_back(it);
    it.key = 32'hFFFF_FFFE; pending_items.push_back(it);
    recent_keys.push_back(32'h0000_0000);

    for (int n = 0; n < NumRandom; n++) begin
      if (n < 150) add_pct = 70;
      else if (n < 500) add_pct = 50;
      else if (n < 900) add_pct = 25;
      else if (n < 1200) add_pct = 80;
      else add_pct = 45;
      it.drain = (n == 0 || n == 600 || n == 1300);
      it.gap = (n >= 700 && n < 900) ? 0 : pick_gap();
      r = $urandom_range(99);
      if ($urandom_range(99) < add_pct) begin
        it.cmd = rhs_pkg::CmdAdd;
        if (r < 70) it.key = $urandom;
        else if (r < 90) it.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else it.key = corner_keys[$urandom_range(corner_keys.size() - 1)];
        recent_keys.push_back(it.key);
        if (recent_keys.size() > Depth + 32) void'(recent_keys.pop_front());
      end else begin
        it.cmd = rhs_pkg::CmdQuery;
        it.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (r >= 50 && r < 65) it.key = it.key ^ (32'h1 << $urandom_range(rhs_pkg::KeyW - 1));
        else if (r >= 65) it.key = $urandom;
      end
      pending_items.push_back(it);
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_failures == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures, %0d results outstanding", n_failures,
               expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
